FILE: rtl/core/box_filter_image_downscale_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the box filter downscaler checks.
// Each macro expects a clock named i_clk in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_IMAGE_DOWNSCALE_ASSERT_SVH
`define BOX_FILTER_IMAGE_DOWNSCALE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define BFD_ASSERT_IMP(lbl, rst_n, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bfd check failed: same-cycle implication");

// Next-cycle implication, off while reset is asserted.
`define BFD_ASSERT_NXT(lbl, rst_n, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bfd check failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define BFD_ASSERT_NXT_RAW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("bfd check failed: reset behavior");

`endif

FILE: rtl/core/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// Sizes, codes, types and the reciprocal table of the box filter downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_FACTOR = 16;

    localparam int PIX_W      = 16;
    localparam int SUM_W      = 24;
    localparam int FACTOR_W   = 5;
    localparam int DIM_W      = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PHASE_W    = $clog2(MAX_FACTOR);
    localparam int RECIP_W    = 32;
    localparam int PROD_W     = SUM_W + RECIP_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT     = 2'd2;

    // Register values after reset
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 5'd2;
    localparam logic [DIM_W-1:0]    WIDTH_RST  = 13'd4096;
    localparam logic [DIM_W-1:0]    HEIGHT_RST = 13'd4096;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic [SUM_W-1:0] t_sum;

    // Per-beat control carried from the position counters to the sum stage
    typedef struct packed {
        logic active;
        logic first;
        logic emit;
        logic row_end;
        logic plane_end;
    } t_beat_ctrl;

    // One finished output beat
    typedef struct packed {
        t_pixel avg_pixel;
        logic   row_end;
        logic   plane_end;
    } t_result;

    // ceil(2^32 / f^2) for f = 2..16, indexed by f-1; f = 1 (entry 0) bypasses the multiply.
    // With sums below 2^24 the truncated product equals the exact quotient.
    localparam logic [RECIP_W-1:0] RECIP [MAX_FACTOR] = '{
        32'd0,
        32'd1073741824,
        32'd477218589,
        32'd268435456,
        32'd171798692,
        32'd119304648,
        32'd87652394,
        32'd67108864,
        32'd53024288,
        32'd42949673,
        32'd35495598,
        32'd29826162,
        32'd25414008,
        32'd21913099,
        32'd19088744,
        32'd16777216
    };

endpackage

`default_nettype wire

FILE: rtl/core/bfd_channels.sv
// ----------------------------------------------------------------------------
// bfd channels
// Valid/ready channels for input pixels and averaged output pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfd_pix_if;
    logic            valid;
    logic            ready;
    bfd_pkg::t_pixel pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bfd_res_if;
    logic            valid;
    logic            ready;
    bfd_pkg::t_pixel avg_pixel;
    logic            row_end;
    logic            plane_end;

    modport source (output valid, output avg_pixel, output row_end, output plane_end,
                    input ready);
    modport sink   (input valid, input avg_pixel, input row_end, input plane_end,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/box_filter_image_downscale.sv
// ----------------------------------------------------------------------------
// box_filter_image_downscale
// Integer box-filter downscaler: pixels in raster order, one averaged pixel
// per factor-by-factor box out, with row and plane end flags.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix  : one 16-bit pixel per beat, raster order, planes back to back.
//   o_res  : one averaged pixel per finished box, flagged at the end of each
//            output row and output plane.
//   i_cfg_*: write shrink factor, input width and input height while idle;
//            a write to any of them restarts at the top-left of a new plane.
// Throughput: one pixel per cycle while i_pix.ready is high. The column-sum
//   memory is read in the accept cycle and written back in the cycle after;
//   a one-entry forward path covers back-to-back beats on the same column.
// Result path: a box's last pixel goes through the memory read, the sum and
//   write-back, and the reciprocal multiply into the output queue.
// Reset: counters restart at a new plane, registers return to factor 2 and
//   4096 x 4096; the memory needs no clearing since each box opens by a write.
// Stall: a four-beat output queue absorbs results; i_pix.ready drops when
//   the queue plus results in flight would fill it.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_image_downscale (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    bfd_pix_if.sink                            i_pix,
    bfd_res_if.source                          o_res,
    input  logic                               i_cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bfd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [bfd_pkg::FACTOR_W-1:0] r_factor;
    logic [bfd_pkg::DIM_W-1:0]    r_width;
    logic [bfd_pkg::DIM_W-1:0]    r_height;
    logic                         cfg_hit;

    // Effective (clamped) settings
    logic [bfd_pkg::FACTOR_W-1:0] f_c;
    logic [bfd_pkg::FACTOR_W-1:0] f_m1;
    logic [bfd_pkg::DIM_W-1:0]    w_c;
    logic [bfd_pkg::DIM_W-1:0]    h_c;
    logic [bfd_pkg::DIM_W-1:0]    w_m1;
    logic [bfd_pkg::DIM_W-1:0]    h_m1;

    // Position counters
    logic [bfd_pkg::COL_W-1:0]   r_in_col,   n_in_col;
    logic [bfd_pkg::ROW_W-1:0]   r_in_row,   n_in_row;
    logic [bfd_pkg::PHASE_W-1:0] r_col_ph,   n_col_ph;
    logic [bfd_pkg::PHASE_W-1:0] r_row_ph,   n_row_ph;
    logic [bfd_pkg::COL_W-1:0]   r_box_col,  n_box_col;
    logic [bfd_pkg::COL_W-1:0]   r_col_base, n_col_base;
    logic [bfd_pkg::ROW_W-1:0]   r_row_base, n_row_base;

    logic                        acc;
    logic                        col_last;
    logic                        row_last;
    logic                        line_last;
    logic                        plane_last;
    logic [bfd_pkg::DIM_W-1:0]   col_fit;
    logic [bfd_pkg::DIM_W-1:0]   row_fit;
    logic [bfd_pkg::DIM_W-1:0]   col_next_fit;
    logic [bfd_pkg::DIM_W-1:0]   row_next_fit;
    bfd_pkg::t_beat_ctrl         a_ctrl;

    // Sum stage
    logic                        r_b_valid;
    bfd_pkg::t_pixel             r_b_px;
    logic [bfd_pkg::COL_W-1:0]   r_b_addr;
    bfd_pkg::t_beat_ctrl         r_b_ctrl;
    bfd_pkg::t_sum               r_rd_data;
    bfd_pkg::t_sum               b_old;
    bfd_pkg::t_sum               b_sum;
    logic                        b_wr;
    logic                        b_emit;
    logic                        r_fwd_valid;
    logic [bfd_pkg::COL_W-1:0]   r_fwd_addr;
    bfd_pkg::t_sum               r_fwd_sum;

    // Column-sum memory
    bfd_pkg::t_sum               r_sums [bfd_pkg::MAX_WIDTH];

    // Divide stage
    logic                        r_c_valid;
    bfd_pkg::t_sum               r_c_sum;
    logic                        r_c_re;
    logic                        r_c_pe;
    logic [bfd_pkg::PROD_W-1:0]  prod;
    bfd_pkg::t_pixel             quot;

    // Output queue
    bfd_pkg::t_result             r_fifo [bfd_pkg::FIFO_DEPTH];
    logic [bfd_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [bfd_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [bfd_pkg::FIFO_CNT_W-1:0] r_cnt;
    logic                           pop;
    logic [bfd_pkg::FIFO_CNT_W:0]   pending;
    bfd_pkg::t_result               head;

    // Decode configuration writes
    always_comb begin
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bfd_pkg::CFG_SHRINK_FACTOR,
                bfd_pkg::CFG_IN_WIDTH,
                bfd_pkg::CFG_IN_HEIGHT: cfg_hit = 1'b1;
                default:                cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= bfd_pkg::FACTOR_RST;
            r_width  <= bfd_pkg::WIDTH_RST;
            r_height <= bfd_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bfd_pkg::CFG_SHRINK_FACTOR: r_factor <= i_cfg_data[bfd_pkg::FACTOR_W-1:0];
                bfd_pkg::CFG_IN_WIDTH:      r_width  <= i_cfg_data;
                bfd_pkg::CFG_IN_HEIGHT:     r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp settings to their usable ranges
    always_comb begin
        if (r_factor == '0) begin
            f_c = bfd_pkg::FACTOR_W'(1);
        end else if (r_factor > bfd_pkg::FACTOR_W'(bfd_pkg::MAX_FACTOR)) begin
            f_c = bfd_pkg::FACTOR_W'(bfd_pkg::MAX_FACTOR);
        end else begin
            f_c = r_factor;
        end
        if (r_width == '0) begin
            w_c = bfd_pkg::DIM_W'(1);
        end else if (r_width > bfd_pkg::DIM_W'(bfd_pkg::MAX_WIDTH)) begin
            w_c = bfd_pkg::DIM_W'(bfd_pkg::MAX_WIDTH);
        end else begin
            w_c = r_width;
        end
        if (r_height == '0) begin
            h_c = bfd_pkg::DIM_W'(1);
        end else if (r_height > bfd_pkg::DIM_W'(bfd_pkg::MAX_HEIGHT)) begin
            h_c = bfd_pkg::DIM_W'(bfd_pkg::MAX_HEIGHT);
        end else begin
            h_c = r_height;
        end
    end

    assign f_m1 = f_c - bfd_pkg::FACTOR_W'(1);
    assign w_m1 = w_c - bfd_pkg::DIM_W'(1);
    assign h_m1 = h_c - bfd_pkg::DIM_W'(1);

    // Box position: a box is live when it ends inside the row / plane
    assign acc          = i_pix.valid && i_pix.ready;
    assign col_last     = {1'b0, r_col_ph} == f_m1;
    assign row_last     = {1'b0, r_row_ph} == f_m1;
    assign line_last    = r_in_col == w_m1[bfd_pkg::COL_W-1:0];
    assign plane_last   = r_in_row == h_m1[bfd_pkg::ROW_W-1:0];
    assign col_fit      = {1'b0, r_col_base} + bfd_pkg::DIM_W'(f_c);
    assign row_fit      = {1'b0, r_row_base} + bfd_pkg::DIM_W'(f_c);
    assign col_next_fit = col_fit + bfd_pkg::DIM_W'(f_c);
    assign row_next_fit = row_fit + bfd_pkg::DIM_W'(f_c);

    always_comb begin
        a_ctrl.active    = (col_fit <= w_c) && (row_fit <= h_c);
        a_ctrl.first     = (r_col_ph == '0) && (r_row_ph == '0);
        a_ctrl.emit      = a_ctrl.active && col_last && row_last;
        a_ctrl.row_end   = col_next_fit > w_c;
        a_ctrl.plane_end = (col_next_fit > w_c) && (row_next_fit > h_c);
    end

    // Advance the position on each accepted beat; a configuration write restarts it
    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_col_ph   = r_col_ph;
        n_row_ph   = r_row_ph;
        n_box_col  = r_box_col;
        n_col_base = r_col_base;
        n_row_base = r_row_base;
        if (cfg_hit) begin
            n_in_col   = '0;
            n_in_row   = '0;
            n_col_ph   = '0;
            n_row_ph   = '0;
            n_box_col  = '0;
            n_col_base = '0;
            n_row_base = '0;
        end else if (acc) begin
            if (col_last) begin
                n_col_ph   = '0;
                n_box_col  = r_box_col + bfd_pkg::COL_W'(1);
                n_col_base = r_col_base + bfd_pkg::COL_W'(f_c);
            end else begin
                n_col_ph   = r_col_ph + bfd_pkg::PHASE_W'(1);
            end
            n_in_col = r_in_col + bfd_pkg::COL_W'(1);
            if (line_last) begin
                n_in_col   = '0;
                n_col_ph   = '0;
                n_box_col  = '0;
                n_col_base = '0;
                n_in_row   = r_in_row + bfd_pkg::ROW_W'(1);
                if (row_last) begin
                    n_row_ph   = '0;
                    n_row_base = r_row_base + bfd_pkg::ROW_W'(f_c);
                end else begin
                    n_row_ph   = r_row_ph + bfd_pkg::PHASE_W'(1);
                end
                if (plane_last) begin
                    n_in_row   = '0;
                    n_row_ph   = '0;
                    n_row_base = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_col_ph   <= '0;
            r_row_ph   <= '0;
            r_box_col  <= '0;
            r_col_base <= '0;
            r_row_base <= '0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_col_ph   <= n_col_ph;
            r_row_ph   <= n_row_ph;
            r_box_col  <= n_box_col;
            r_col_base <= n_col_base;
            r_row_base <= n_row_base;
        end
    end

    // Register the accepted beat for the sum stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_px   <= i_pix.pixel;
            r_b_addr <= r_box_col;
            r_b_ctrl <= a_ctrl;
        end
    end

    // Column-sum memory: read at the current box column, write back the new sum
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_sums[r_box_col];
        if (b_wr) begin
            r_sums[r_b_addr] <= b_sum;
        end
    end

    // Forward the sum written at the same edge as this beat's read
    assign b_old  = (r_fwd_valid && (r_fwd_addr == r_b_addr)) ? r_fwd_sum : r_rd_data;
    assign b_sum  = r_b_ctrl.first ? bfd_pkg::SUM_W'(r_b_px)
                                   : b_old + bfd_pkg::SUM_W'(r_b_px);
    assign b_wr   = r_b_valid && r_b_ctrl.active;
    assign b_emit = r_b_valid && r_b_ctrl.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
            r_c_valid   <= 1'b0;
        end else begin
            r_fwd_valid <= b_wr;
            r_c_valid   <= b_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_b_addr;
        r_fwd_sum  <= b_sum;
        r_c_sum    <= b_sum;
        r_c_re     <= r_b_ctrl.row_end;
        r_c_pe     <= r_b_ctrl.plane_end;
    end

    // Divide by factor squared through the reciprocal table
    assign prod = bfd_pkg::PROD_W'(r_c_sum)
                * bfd_pkg::PROD_W'(bfd_pkg::RECIP[f_m1[bfd_pkg::PHASE_W-1:0]]);
    assign quot = (f_c == bfd_pkg::FACTOR_W'(1))
                ? r_c_sum[bfd_pkg::PIX_W-1:0]
                : prod[bfd_pkg::RECIP_W +: bfd_pkg::PIX_W];

    // Output queue: push finished results, pop on each output beat
    assign pop  = o_res.valid && o_res.ready;
    assign head = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (r_c_valid) begin
            r_fifo[r_wr_ptr] <= '{avg_pixel: quot, row_end: r_c_re, plane_end: r_c_pe};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_c_valid) begin
                r_wr_ptr <= r_wr_ptr + bfd_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + bfd_pkg::FIFO_PTR_W'(1);
            end
            case ({r_c_valid, pop})
                2'b10:   r_cnt <= r_cnt + bfd_pkg::FIFO_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - bfd_pkg::FIFO_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Hold off input when the queue could not take every result in flight
    assign pending     = (bfd_pkg::FIFO_CNT_W + 1)'(r_cnt)
                       + (bfd_pkg::FIFO_CNT_W + 1)'(b_emit)
                       + (bfd_pkg::FIFO_CNT_W + 1)'(r_c_valid);
    assign i_pix.ready = pending < (bfd_pkg::FIFO_CNT_W + 1)'(bfd_pkg::FIFO_DEPTH);

    assign o_res.valid     = r_cnt != '0;
    assign o_res.avg_pixel = head.avg_pixel;
    assign o_res.row_end   = head.row_end;
    assign o_res.plane_end = head.plane_end;

endmodule

`default_nettype wire

FILE: rtl/core/bfd_checker.sv
// ----------------------------------------------------------------------------
// bfd_checker
// Port-level checks for the box filter downscaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_filter_image_downscale_assert.svh"

module bfd_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [bfd_pkg::PIX_W-1:0] i_avg_pixel,
    input logic                  i_row_end,
    input logic                  i_plane_end
);

    // Hold a stalled output beat
    `BFD_ASSERT_NXT(a_out_hold, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_avg_pixel) && $stable(i_row_end) && $stable(i_plane_end))

    // Plane end only on the last pixel of a row
    `BFD_ASSERT_IMP(a_plane_row, i_rst_n, i_out_valid && i_plane_end, i_row_end)

    // Leave reset with an empty output and input open
    `BFD_ASSERT_NXT_RAW(a_reset_empty, !i_rst_n, !i_out_valid && i_in_ready)

    // A result appearing on an empty output traces back to an input beat
    `BFD_ASSERT_IMP(a_out_cause, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 3))

endmodule

bind box_filter_image_downscale bfd_checker u_bfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_avg_pixel (o_res.avg_pixel),
    .i_row_end   (o_res.row_end),
    .i_plane_end (o_res.plane_end)
);

`default_nettype wire
